// File: hw/rtl/bsog_pkg.sv
// Shared constants, register codes and types of the broadcast strided offset generator.
package bsog_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = 16;
    localparam int STRIDE_SLOT = 32;
    localparam int IDX_W       = 48;
    localparam int OFS_W       = 52;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int RANK_W      = 3;
    localparam int BASE_W      = 48;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    localparam int DEF_MAX_RANK    = 4;
    localparam int DEF_DIM_BITS    = 16;
    localparam int DEF_STRIDE_BITS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_RANK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_DIMS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_DIMS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_LO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_HI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 3'd6;

    typedef struct packed {
        logic oor;
        logic rerr;
    } t_flags;

endpackage

// File: hw/rtl/broadcast_strided_offset_gen.sv
// Broadcast strided offset generator: linear index to strided storage offset, fully pipelined.
//
// Accepts one linear index per cycle and returns one storage offset per cycle. The pipeline
// depth is set by the restoring division chain that peels one coordinate bit per stage off
// the index for the three outer logical dimensions. A stall on the result side holds the whole
// pipeline. The user must write configuration registers only while no request is in flight;
// the block itself does not enforce this. Suffix products derived from them are registered
// and settle before a following request reaches the range check.
module broadcast_strided_offset_gen #(
    parameter int MAX_RANK    = bsog_pkg::DEF_MAX_RANK,
    parameter int DIM_BITS    = bsog_pkg::DEF_DIM_BITS,
    parameter int STRIDE_BITS = bsog_pkg::DEF_STRIDE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsog_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bsog_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bsog_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // element index
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bsog_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,  // element offset, zero pad
    output logic [bsog_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser   // index_out_of_range, rank_error
);
    import bsog_pkg::*;

    localparam int DB    = DIM_BITS;
    localparam int SB    = STRIDE_BITS;
    localparam int LIM   = (MAX_RANK < SLOTS) ? MAX_RANK : SLOTS;
    localparam int NDIV  = 3 * DB;
    localparam int CW    = (IDX_W > 4 * DB) ? IDX_W : 4 * DB;
    localparam int TW    = DB + SB;
    localparam logic [RANK_W-1:0] LIM_R = RANK_W'(LIM);

    // configuration
    logic [RANK_W-1:0] r_lrank, r_srank;
    logic [CFG_W-1:0]  r_ldims, r_sdims, r_str_lo, r_str_hi;
    logic [BASE_W-1:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lrank  <= '0;
            r_srank  <= '0;
            r_ldims  <= '0;
            r_sdims  <= '0;
            r_str_lo <= '0;
            r_str_hi <= '0;
            r_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOGICAL_RANK: r_lrank  <= i_cfg_data[RANK_W-1:0];
                REG_SOURCE_RANK:  r_srank  <= i_cfg_data[RANK_W-1:0];
                REG_LOGICAL_DIMS: r_ldims  <= i_cfg_data;
                REG_SOURCE_DIMS:  r_sdims  <= i_cfg_data;
                REG_STRIDES_LO:   r_str_lo <= i_cfg_data;
                REG_STRIDES_HI:   r_str_hi <= i_cfg_data;
                REG_BASE_OFFSET:  r_base   <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [RANK_W-1:0] w_lr, w_sr;
    assign w_lr = (r_lrank > LIM_R) ? LIM_R : r_lrank;
    assign w_sr = (r_srank > LIM_R) ? LIM_R : r_srank;

    // suffix products and element count, padding dimensions read as 1
    logic [SLOTS-1:0][DB-1:0] w_ld;
    always_comb begin
        for (int d = 0; d < SLOTS; d++) begin
            w_ld[d] = (RANK_W'(d) < w_lr) ? r_ldims[SLOT_W*d +: DB] : DB'(1);
        end
    end

    logic [2*DB-1:0] r_p01, r_p23;
    logic [3*DB-1:0] r_suf [3];
    logic [4*DB-1:0] r_count;

    always_ff @(posedge i_clk) begin
        r_p01   <= w_ld[0] * w_ld[1];
        r_p23   <= w_ld[2] * w_ld[3];
        r_suf[0] <= w_ld[1] * r_p23;
        r_suf[1] <= (3*DB)'(r_p23);
        r_suf[2] <= (3*DB)'(w_ld[3]);
        r_count <= r_p01 * r_p23;
    end

    // handshake
    logic w_adv;
    logic r_f_vld;
    assign w_adv           = !r_f_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // stages A and B: hold the index while derived values settle
    logic             r_a_vld, r_b_vld;
    logic [IDX_W-1:0] r_a_idx, r_b_idx;

    // stage C is division step 0
    logic [NDIV:0]             r_dv_vld;
    logic [IDX_W-1:0]          r_rem [NDIV+1];
    logic [2:0][DB-1:0]        r_crd [NDIV+1];
    t_flags                    r_flg [NDIV+1];

    t_flags n_flg;
    always_comb begin
        n_flg.oor  = CW'(r_b_idx) >= CW'(r_count);
        n_flg.rerr = w_sr > w_lr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_a_vld     <= i_s_axis_tvalid;
            r_b_vld     <= r_a_vld;
            r_dv_vld[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_idx  <= i_s_axis_tdata[IDX_W-1:0];
            r_b_idx  <= r_a_idx;
            r_rem[0] <= r_b_idx;
            r_crd[0] <= '0;
            r_flg[0] <= n_flg;
        end
    end

    // restoring division, one coordinate bit per stage
    for (genvar s = 1; s <= NDIV; s++) begin : g_div
        localparam int K = (s - 1) / DB;
        localparam int B = DB - 1 - ((s - 1) % DB);
        logic [CW-1:0]      w_trial, w_rem;
        logic               w_ge;
        logic [2:0][DB-1:0] n_crd;
        assign w_trial = CW'(r_suf[K]) << B;
        assign w_rem   = CW'(r_rem[s-1]);
        assign w_ge    = w_rem >= w_trial;

        always_comb begin
            n_crd       = r_crd[s-1];
            n_crd[K][B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[s] <= r_dv_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[s] <= w_ge ? IDX_W'(w_rem - w_trial) : r_rem[s-1];
                r_crd[s] <= n_crd;
                r_flg[s] <= r_flg[s-1];
            end
        end
    end

    // stage D: coordinate times stride per logical slot
    logic                r_d_vld;
    logic [TW-1:0]       r_term [SLOTS];
    t_flags              r_d_flg;
    logic [TW-1:0]       n_term [SLOTS];

    always_comb begin
        logic [RANK_W:0]   sum;
        logic [1:0]        sd;
        logic              used;
        logic [DB-1:0]     crd;
        logic [DB-1:0]     sdim;
        logic [CFG_W-1:0]  sreg;
        logic [SB-1:0]     strd;
        for (int d = 0; d < SLOTS; d++) begin
            sum  = (RANK_W+1)'(d) + {1'b0, w_sr};
            used = (RANK_W'(d) < w_lr) && (sum >= {1'b0, w_lr});
            sd   = 2'(sum - {1'b0, w_lr});
            crd  = (d < 3) ? r_crd[NDIV][d % 3] : r_rem[NDIV][DB-1:0];
            sdim = r_sdims[SLOT_W*sd +: DB];
            sreg = sd[1] ? r_str_hi : r_str_lo;
            strd = sreg[STRIDE_SLOT*sd[0] +: SB];
            n_term[d] = (used && (sdim != DB'(1))) ? crd * strd : '0;
        end
    end

    // stage E: pair sums
    logic              r_e_vld;
    logic [TW:0]       r_s01, r_s23;
    t_flags            r_e_flg;

    // stage F: output register
    logic [OFS_W-1:0]  r_f_ofs;
    t_flags            r_f_flg;
    logic [OFS_W-1:0]  n_f_ofs;

    assign n_f_ofs = (r_e_flg.oor || r_e_flg.rerr) ? OFS_W'(r_base)
                   : OFS_W'(r_base) + OFS_W'(r_s01) + OFS_W'(r_s23);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_dv_vld[NDIV];
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int d = 0; d < SLOTS; d++) begin
                r_term[d] <= n_term[d];
            end
            r_d_flg <= r_flg[NDIV];
            r_s01   <= (TW+1)'(r_term[0]) + (TW+1)'(r_term[1]);
            r_s23   <= (TW+1)'(r_term[2]) + (TW+1)'(r_term[3]);
            r_e_flg <= r_d_flg;
            r_f_ofs <= n_f_ofs;
            r_f_flg <= r_e_flg;
        end
    end

    assign o_m_axis_tvalid = r_f_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OFS_W){1'b0}}, r_f_ofs};
    assign o_m_axis_tuser  = {r_f_flg.rerr, r_f_flg.oor};

endmodule

// File: bench/broadcast_strided_offset_gen_test.sv
// Testbench of the broadcast strided offset generator: random and directed requests.
module broadcast_strided_offset_gen_test;
    import bsog_pkg::*;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic             oor;
        logic             rerr;
    } t_offset_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    broadcast_strided_offset_gen uut (.*);

    always #5 i_clk = ~i_clk;

    logic [RANK_W-1:0] cur_lrank, cur_srank;
    logic [CFG_W-1:0]  cur_ldims, cur_sdims, cur_str_lo, cur_str_hi;
    logic [BASE_W-1:0] cur_base;

    logic [IDX_W-1:0]  pending_idx[$];
    t_offset_result    expected_offsets[$];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_off_cycles = 0;
    bit                hold_off_req = 1'b0;
    bit                hold_off_taken = 1'b0;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    function automatic logic [63:0] slot_size(logic [CFG_W-1:0] r, int d);
        return 64'(r[16*d +: 16]);
    endfunction

    function automatic logic [63:0] slot_stride(int d);
        logic [CFG_W-1:0] r;
        r = (d >= 2) ? cur_str_hi : cur_str_lo;
        return 64'(r[32*(d%2) +: 32]);
    endfunction

    function automatic t_offset_result compute_offset(logic [IDX_W-1:0] idx);
        t_offset_result res;
        int lr, sr;
        logic [63:0] count, rem, suffix, coord, ofs;
        lr = (cur_lrank > 4) ? 4 : int'(cur_lrank);
        sr = (cur_srank > 4) ? 4 : int'(cur_srank);
        count = 1;
        for (int d = 0; d < lr; d++) count = count * slot_size(cur_ldims, d);
        ofs = 64'(cur_base);
        rem = 64'(idx);
        res.oor = 64'(idx) >= count;
        res.rerr = sr > lr;
        if (!res.oor && !res.rerr) begin
            for (int d = 0; d < lr; d++) begin
                suffix = 1;
                for (int j = d + 1; j < lr; j++) suffix = suffix * slot_size(cur_ldims, j);
                if (suffix == 0) begin
                    coord = 0;
                    rem = 0;
                end else begin
                    coord = rem / suffix;
                    rem = rem % suffix;
                end
                if (d + sr >= lr && slot_size(cur_sdims, d + sr - lr) != 1)
                    ofs = ofs + coord * slot_stride(d + sr - lr);
            end
        end
        res.offset = ofs[OFS_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_offsets.push_back(compute_offset(i_s_axis_tdata));
                void'(pending_idx.pop_front());
            end
            if (pending_idx.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pending_idx[0];
            end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                t_offset_result got, want;
                got.offset = o_m_axis_tdata[OFS_W-1:0];
                got.oor = o_m_axis_tuser[0];
                got.rerr = o_m_axis_tuser[1];
                if (expected_offsets.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_offsets.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: offset %h oor %b rerr %b, expected %h %b %b",
                                     got.offset, got.oor, got.rerr,
                                     want.offset, want.oor, want.rerr);
                    end
                end
            end
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken <= 1'b1;
                hold_off_cycles <= 300;
                i_m_axis_tready <= 1'b0;
            end else if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (pending_idx.size() == 0 && expected_offsets.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_idx.size() == 0 && expected_offsets.size() == 0);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_LOGICAL_RANK: cur_lrank = val[RANK_W-1:0];
            REG_SOURCE_RANK:  cur_srank = val[RANK_W-1:0];
            REG_LOGICAL_DIMS: cur_ldims = val;
            REG_SOURCE_DIMS:  cur_sdims = val;
            REG_STRIDES_LO:   cur_str_lo = val;
            REG_STRIDES_HI:   cur_str_hi = val;
            default:          cur_base = val[BASE_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(9))
            0: return 16'd1;
            1: return 16'hffff;
            2: return 16'd0;
            3, 4: return 16'($urandom_range(2, 300));
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_setting();
        logic [63:0] ld, sd;
        int lr;
        lr = $urandom_range(7);
        for (int d = 0; d < 4; d++) begin
            ld[16*d +: 16] = ($urandom_range(19) == 0) ? 16'd0 : rand_size();
            sd[16*d +: 16] = ($urandom_range(2) == 0) ? 16'd1 : rand_size();
        end
        write_reg(REG_LOGICAL_RANK, 64'(lr));
        write_reg(REG_SOURCE_RANK,
                  ($urandom_range(5) == 0) ? 64'($urandom_range(7)) : 64'($urandom_range(lr)));
        write_reg(REG_LOGICAL_DIMS, ld);
        write_reg(REG_SOURCE_DIMS, sd);
        write_reg(REG_STRIDES_LO, ($urandom_range(5) == 0) ? '1 : rand64());
        write_reg(REG_STRIDES_HI, ($urandom_range(5) == 0) ? '1 : rand64());
        write_reg(REG_BASE_OFFSET, ($urandom_range(5) == 0) ? 64'hffff_ffff_ffff : rand64());
    endtask

    function automatic logic [IDX_W-1:0] random_index();
        logic [63:0] count;
        int lr;
        lr = (cur_lrank > 4) ? 4 : int'(cur_lrank);
        count = 1;
        for (int d = 0; d < lr; d++) count = count * slot_size(cur_ldims, d);
        case ($urandom_range(9))
            0: return '1;
            1: return IDX_W'(count);
            2: return IDX_W'({$urandom, $urandom});
            default: begin
                if (count == 0) return IDX_W'($urandom);
                if (count > 64'hffff_ffff_ffff) return IDX_W'({$urandom, $urandom});
                return IDX_W'(({$urandom, $urandom}) % count);
            end
        endcase
    endfunction

    initial begin
        cur_lrank = '0; cur_srank = '0; cur_ldims = '0; cur_sdims = '0;
        cur_str_lo = '0; cur_str_hi = '0; cur_base = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: rank zero, only index 0 in range
        pending_idx.push_back('0);
        pending_idx.push_back(48'd1);
        pending_idx.push_back('1);
        drain();

        // full rank with maximum sizes and strides
        write_reg(REG_LOGICAL_RANK, 64'd4);
        write_reg(REG_SOURCE_RANK, 64'd4);
        write_reg(REG_LOGICAL_DIMS, '1);
        write_reg(REG_SOURCE_DIMS, 64'hfffe_0001_ffff_fffe);
        write_reg(REG_STRIDES_LO, '1);
        write_reg(REG_STRIDES_HI, '1);
        write_reg(REG_BASE_OFFSET, 64'hffff_ffff_ffff);
        pending_idx.push_back('0);
        pending_idx.push_back('1);
        pending_idx.push_back(48'h5555_aaaa_5555);
        pending_idx.push_back(48'haaaa_5555_aaaa);
        pending_idx.push_back(48'h0001_0001_0001);
        drain();

        // source rank above logical rank, rank register above limit
        write_reg(REG_LOGICAL_RANK, 64'd2);
        write_reg(REG_SOURCE_RANK, 64'd7);
        pending_idx.push_back(48'd3);
        drain();
        write_reg(REG_LOGICAL_RANK, 64'd7);
        write_reg(REG_SOURCE_RANK, 64'd3);
        write_reg(REG_LOGICAL_DIMS, 64'h0005_0000_0003_0002);
        pending_idx.push_back('0);
        pending_idx.push_back(48'd7);
        drain();
        write_reg(REG_LOGICAL_DIMS, 64'h0005_0004_0003_0002);
        write_reg(REG_SOURCE_DIMS, 64'h0005_0001_0003_0001);
        write_reg(REG_STRIDES_LO, 64'h0000_0007_0000_0003);
        write_reg(REG_STRIDES_HI, 64'h0000_0001_0000_0005);
        write_reg(REG_BASE_OFFSET, 64'd100);
        for (int k = 117; k < 122; k++) pending_idx.push_back(IDX_W'(k));
        drain();

        for (int phase = 0; phase < 24; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            random_setting();
            if (phase == 5) hold_off_req = 1'b1;
            for (int k = 0; k < 48; k++) pending_idx.push_back(random_index());
            drain();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
